@@ sv/sync_length_checksum_deframer_defines.svh @@
// Assertion macros shared by the deframer's checker.
// No dependencies; include by bare file name.
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define SLCD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLCD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/slcd_pkg.sv @@
// Shared types and constants for the sync/length/checksum deframer.
// No dependencies.
package slcd_pkg;

   localparam int unsigned CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_LEN     = 2'd2;

   localparam logic [7:0]  SYNC_FIRST_RST  = 8'h4F;
   localparam logic [7:0]  SYNC_SECOND_RST = 8'h50;
   localparam logic [15:0] MAX_LEN_RST     = 16'd192;

   typedef enum logic [1:0] {
      EV_PAYLOAD  = 2'd0,
      EV_GOOD     = 2'd1,
      EV_BAD_SUM  = 2'd2,
      EV_TOO_LONG = 2'd3
   } event_type;

   typedef struct packed {
      logic [7:0]  sync_first;
      logic [7:0]  sync_second;
      logic [15:0] max_len;
   } cfg_type;

   typedef struct packed {
      event_type   kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [7:0]  frame_kind;
      logic [15:0] frame_len;
   } result_type;

endpackage

@@ sv/slcd_parser.sv @@
// Frame parser: sync hunt, header, payload indexing and running checksum.
// Depends on slcd_pkg.
module slcd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [7:0]          in_byte,
   input  slcd_pkg::cfg_type   cfg,
   output logic                res_valid,
   output slcd_pkg::result_type res
);

   typedef enum logic [2:0] {
      PH_SYNC1   = 3'd0,
      PH_SYNC2   = 3'd1,
      PH_TYPE    = 3'd2,
      PH_LEN_LO  = 3'd3,
      PH_LEN_HI  = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_CHECK   = 3'd6
   } phase_type;

   phase_type   phase_ff,  phase_in;
   logic [7:0]  type_ff,   type_in;
   logic [15:0] len_ff,    len_in;
   logic [15:0] count_ff,  count_in;
   logic [7:0]  sum_ff,    sum_in;
   logic [15:0] count_inc;
   logic [15:0] len_full;

   assign count_inc = count_ff + 16'd1;
   assign len_full  = {in_byte, len_ff[7:0]};

   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      res_valid = 1'b0;
      res       = '{kind: slcd_pkg::EV_PAYLOAD, data_byte: 8'd0, byte_index: 16'd0,
                    frame_kind: type_ff, frame_len: len_ff};
      unique case (phase_ff)
         PH_SYNC2: begin
            if (in_byte == cfg.sync_second) begin
               phase_in = PH_TYPE;
            end else if (in_byte != cfg.sync_first) begin
               phase_in = PH_SYNC1;
            end
         end
         PH_TYPE: begin
            type_in  = in_byte;
            sum_in   = in_byte;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_in   = {8'd0, in_byte};
            sum_in   = sum_ff + in_byte;
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            len_in        = len_full;
            sum_in        = sum_ff + in_byte;
            count_in      = 16'd0;
            res.frame_len = len_full;
            if (len_full > cfg.max_len) begin
               res_valid = 1'b1;
               res.kind  = slcd_pkg::EV_TOO_LONG;
               phase_in  = PH_SYNC1;
            end else if (len_full == 16'd0) begin
               phase_in = PH_CHECK;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            res_valid      = 1'b1;
            res.data_byte  = in_byte;
            res.byte_index = count_ff;
            sum_in         = sum_ff + in_byte;
            count_in       = count_inc;
            if (count_inc >= len_ff) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            res_valid = 1'b1;
            res.kind  = (in_byte == sum_ff) ? slcd_pkg::EV_GOOD : slcd_pkg::EV_BAD_SUM;
            phase_in  = PH_SYNC1;
         end
         default: begin
            phase_in = (in_byte == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
         end
      endcase
      if (!in_valid) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         type_ff  <= 8'd0;
         len_ff   <= 16'd0;
         count_ff <= 16'd0;
         sum_ff   <= 8'd0;
      end else if (in_valid) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

@@ sv/sync_length_checksum_deframer.sv @@
// Top level of the sync/length/checksum deframer: config registers and output skid buffer.
// Depends on slcd_pkg and slcd_parser.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata: rx_byte
//   rsp      out  rsp_tvalid/rsp_tready  tuser: event_kind; tdata: result fields
//   csr      in   csr_we                 csr_addr, csr_wdata
//
// One byte per cycle while req_tready is high; each result is registered before rsp shows it.
// The parser state update is the only loop: one byte through it per clock while req_tready is high.
// A two-entry output buffer keeps req_tready registered and lets bytes flow under rsp stall.
// Synchronous reset clears parser state, config to defaults and empties the buffer.
module sync_length_checksum_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] data_byte, [23:8] byte_index,
                                    // [31:24] frame_kind, [47:32] frame_len
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   input  logic        csr_we,
   input  logic [slcd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [15:0] csr_wdata
);

   slcd_pkg::cfg_type    cfg_ff;
   slcd_pkg::result_type res;
   slcd_pkg::result_type main_ff, skid_ff;
   logic                 main_valid_ff, skid_valid_ff;
   logic                 res_valid, accept, push, pop;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign push       = res_valid;
   assign pop        = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{sync_first: slcd_pkg::SYNC_FIRST_RST,
                     sync_second: slcd_pkg::SYNC_SECOND_RST,
                     max_len: slcd_pkg::MAX_LEN_RST};
      end else if (csr_we) begin
         unique case (csr_addr)
            slcd_pkg::CSR_SYNC_FIRST:  cfg_ff.sync_first  <= csr_wdata[7:0];
            slcd_pkg::CSR_SYNC_SECOND: cfg_ff.sync_second <= csr_wdata[7:0];
            slcd_pkg::CSR_MAX_LEN:     cfg_ff.max_len     <= csr_wdata;
            default: ;
         endcase
      end
   end

   slcd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_byte   (req_tdata),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // skid is only ever loaded when main holds an untaken result
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else if (push) begin
            main_ff <= res;
         end else begin
            main_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_ff       <= res;
            main_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= res;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tuser  = main_ff.kind;
   assign rsp_tdata  = {main_ff.frame_len, main_ff.frame_kind, main_ff.byte_index,
                        main_ff.data_byte};

endmodule

@@ sv/slcd_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
// Depends on slcd_pkg and sync_length_checksum_deframer_defines.svh.
`include "sync_length_checksum_deframer_defines.svh"

module slcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   `SLCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp changed under stall")

   `SLCD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid,
      "rsp valid straight after reset")

   `SLCD_ASSERT_NOW(a_extra_zero, clock, reset,
      rsp_tvalid && rsp_tuser != slcd_pkg::EV_PAYLOAD, rsp_tdata[23:0] == 24'd0,
      "data/index not zero on frame event")

   `SLCD_ASSERT_NOW(a_index_range, clock, reset,
      rsp_tvalid && rsp_tuser == slcd_pkg::EV_PAYLOAD, rsp_tdata[23:8] < rsp_tdata[47:32],
      "payload index beyond frame length")

endmodule

bind sync_length_checksum_deframer slcd_checker u_slcd_checker (.*);

@@ test/testbench.sv @@
// Self-checking bench for sync_length_checksum_deframer: byte stream in, event words out.
// Frames, noise and broken frames go in under several sync and length-limit settings.
// Depends on slcd_pkg and the deframer RTL; every word is checked against a local parser or a directed row.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      HUNT_FIRST, HUNT_SECOND, GET_TYPE, GET_LEN_LO, GET_LEN_HI, GET_PAYLOAD, GET_CHECK
   } parse_phase_type;

   typedef struct packed {
      logic [7:0]           rx;
      logic                 pinned;
      slcd_pkg::result_type want;
   } directed_row_type;

   // fixed frames at reset settings: sync 4F/50, limit 192
   localparam directed_row_type DIRECTED [22] = '{
      '{8'h4F, 1'b0, '0},
      '{8'h4F, 1'b0, '0},   // repeated first sync
      '{8'h50, 1'b0, '0},
      '{8'h07, 1'b0, '0},
      '{8'h02, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b1, '{slcd_pkg::EV_PAYLOAD, 8'hFF, 16'd0, 8'h07, 16'd2}},
      '{8'h00, 1'b1, '{slcd_pkg::EV_PAYLOAD, 8'h00, 16'd1, 8'h07, 16'd2}},
      '{8'h08, 1'b1, '{slcd_pkg::EV_GOOD, 8'h00, 16'd0, 8'h07, 16'd2}},
      '{8'h4F, 1'b0, '0},
      '{8'h50, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},   // zero length, straight to checksum
      '{8'h00, 1'b1, '{slcd_pkg::EV_BAD_SUM, 8'h00, 16'd0, 8'hFF, 16'd0}},
      '{8'h4F, 1'b0, '0},
      '{8'h12, 1'b0, '0},   // broken sync, back to hunt
      '{8'h4F, 1'b0, '0},
      '{8'h50, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'hC1, 1'b0, '0},
      '{8'h00, 1'b1, '{slcd_pkg::EV_TOO_LONG, 8'h00, 16'd0, 8'hAA, 16'h00C1}}
   };

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [7:0]                      req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [47:0]                     rsp_tdata;
   logic [1:0]                      rsp_tuser;
   logic                            csr_we;
   logic [slcd_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [15:0]                     csr_wdata;

   slcd_pkg::cfg_type csr_shadow;
   parse_phase_type   hunt_phase;
   logic [7:0]        frame_type;
   logic [15:0]       frame_len_q;
   logic [15:0]       payload_count;
   logic [7:0]        frame_sum;

   slcd_pkg::result_type expected_events[$];
   slcd_pkg::result_type want;
   int         errors;
   int         bytes_sent;
   int         words_seen;
   int         kind_seen [4];
   int         send_idle_pct;
   int         stall_pct;

   sync_length_checksum_deframer uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("sync_length_checksum_deframer test failed");
      $finish;
   end

   function automatic bit parse_byte(input logic [7:0] b, output slcd_pkg::result_type r);
      bit emitted;
      emitted = 1'b0;
      r = '0;
      case (hunt_phase)
         HUNT_SECOND: begin
            if (b == csr_shadow.sync_second) hunt_phase = GET_TYPE;
            else if (b != csr_shadow.sync_first) hunt_phase = HUNT_FIRST;
         end
         GET_TYPE: begin
            frame_type = b;
            frame_sum = b;
            hunt_phase = GET_LEN_LO;
         end
         GET_LEN_LO: begin
            frame_len_q = {8'h00, b};
            frame_sum += b;
            hunt_phase = GET_LEN_HI;
         end
         GET_LEN_HI: begin
            frame_len_q[15:8] = b;
            frame_sum += b;
            payload_count = '0;
            if (frame_len_q > csr_shadow.max_len) begin
               r.kind = slcd_pkg::EV_TOO_LONG;
               emitted = 1'b1;
               hunt_phase = HUNT_FIRST;
            end else if (frame_len_q == 16'd0) begin
               hunt_phase = GET_CHECK;
            end else begin
               hunt_phase = GET_PAYLOAD;
            end
         end
         GET_PAYLOAD: begin
            r.kind = slcd_pkg::EV_PAYLOAD;
            r.data_byte = b;
            r.byte_index = payload_count;
            emitted = 1'b1;
            frame_sum += b;
            payload_count += 16'd1;
            if (payload_count >= frame_len_q) hunt_phase = GET_CHECK;
         end
         GET_CHECK: begin
            r.kind = (b == frame_sum) ? slcd_pkg::EV_GOOD : slcd_pkg::EV_BAD_SUM;
            emitted = 1'b1;
            hunt_phase = HUNT_FIRST;
         end
         default: begin
            if (b == csr_shadow.sync_first) hunt_phase = HUNT_SECOND;
            else hunt_phase = HUNT_FIRST;
         end
      endcase
      r.frame_kind = frame_type;
      r.frame_len = frame_len_q;
      return emitted;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint exp_val);
      $display("ERROR at %0t: %s: got %0h, wanted %0h", $time, what, got, exp_val);
      errors++;
   endtask

   // called at a falling edge; returns at a falling edge with the byte taken
   task automatic send_byte(input logic [7:0] b, input bit pinned = 1'b0,
                            input slcd_pkg::result_type pinned_word = '0);
      slcd_pkg::result_type r;
      bit                   emitted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      emitted = parse_byte(b, r);
      if (pinned) expected_events.push_back(pinned_word);
      else if (emitted) expected_events.push_back(r);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [slcd_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [15:0] val);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= val;
      case (addr)
         slcd_pkg::CSR_SYNC_FIRST:  csr_shadow.sync_first = val[7:0];
         slcd_pkg::CSR_SYNC_SECOND: csr_shadow.sync_second = val[7:0];
         slcd_pkg::CSR_MAX_LEN:     csr_shadow.max_len = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // well-formed frame most of the time; otherwise noise, an over-long length, truncation or a bad checksum
   task automatic emit_frame(input int forced_len = -1);
      int unsigned pick, lim, len, cut, i;
      logic [7:0]  sum;
      logic [7:0]  b;
      pick = $urandom_range(99);
      lim = csr_shadow.max_len;
      if (forced_len < 0 && pick < 10) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
         return;
      end
      if ($urandom_range(7) == 0) send_byte(csr_shadow.sync_first);
      send_byte(csr_shadow.sync_first);
      send_byte(csr_shadow.sync_second);
      if (forced_len >= 0) len = forced_len;
      else if ($urandom_range(99) < 12 && lim < 65535)
         len = lim + 1 + $urandom_range(0, 65534 - lim);
      else if ($urandom_range(99) < 10 && lim <= 48) len = lim;
      else len = $urandom_range(0, (lim < 10) ? lim : 10);
      b = 8'($urandom_range(255));
      send_byte(b);
      sum = b;
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      sum += len[7:0];
      sum += len[15:8];
      if (len > lim) return;
      cut = (forced_len < 0 && pick < 18) ? $urandom_range(0, len) : len + 1;
      for (i = 0; i < len && i < cut; i++) begin
         b = 8'($urandom_range(255));
         send_byte(b);
         sum += b;
      end
      if (cut <= len) return;
      if (forced_len < 0 && pick < 30) send_byte(sum ^ 8'($urandom_range(1, 255)));
      else send_byte(sum);
   endtask

   task automatic run_phase(input logic [7:0] sync1, input logic [7:0] sync2,
                            input logic [15:0] max_len, input int idle, input int stall,
                            input int n_bytes);
      int start;
      drain();
      write_reg(slcd_pkg::CSR_SYNC_FIRST, {8'h00, sync1});
      write_reg(slcd_pkg::CSR_SYNC_SECOND, {8'h00, sync2});
      write_reg(slcd_pkg::CSR_MAX_LEN, max_len);
      send_idle_pct = idle;
      stall_pct = stall;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         emit_frame();
         if ($urandom_range(19) == 0) drain();
      end
   endtask

   always @(negedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         kind_seen[rsp_tuser]++;
         if (expected_events.size() == 0) begin
            report_mismatch("unexpected word, kind", rsp_tuser, 0);
         end else begin
            want = expected_events.pop_front();
            if (rsp_tuser != want.kind) report_mismatch("event_kind", rsp_tuser, want.kind);
            if (rsp_tdata[7:0] != want.data_byte)
               report_mismatch("data_byte", rsp_tdata[7:0], want.data_byte);
            if (rsp_tdata[23:8] != want.byte_index)
               report_mismatch("byte_index", rsp_tdata[23:8], want.byte_index);
            if (rsp_tdata[31:24] != want.frame_kind)
               report_mismatch("frame_kind", rsp_tdata[31:24], want.frame_kind);
            if (rsp_tdata[47:32] != want.frame_len)
               report_mismatch("frame_len", rsp_tdata[47:32], want.frame_len);
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      errors = 0;
      bytes_sent = 0;
      words_seen = 0;
      kind_seen = '{default: 0};
      send_idle_pct = 0;
      stall_pct = 0;
      csr_shadow = '{slcd_pkg::SYNC_FIRST_RST, slcd_pkg::SYNC_SECOND_RST,
                     slcd_pkg::MAX_LEN_RST};
      hunt_phase = HUNT_FIRST;
      frame_type = '0;
      frame_len_q = '0;
      payload_count = '0;
      frame_sum = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) send_byte(DIRECTED[i].rx, DIRECTED[i].pinned, DIRECTED[i].want);

      run_phase(slcd_pkg::SYNC_FIRST_RST, slcd_pkg::SYNC_SECOND_RST, slcd_pkg::MAX_LEN_RST,
                0, 0, 110);
      run_phase(8'h00, 8'hFF, 16'd0, 73, 0, 110);
      run_phase(8'hA5, 8'hA5, 16'd3, 0, 73, 110);
      // one frame longer than 255 bytes, its length carries into the upper length byte
      run_phase(8'hFF, 8'h00, 16'hFFFF, 0, 0, 20);
      emit_frame(256);
      run_phase(8'hFF, 8'h00, 16'hFFFF, 16, 16, 110);
      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                16'($urandom_range(65535)), 16, 16, 110);
      drain();

      if (expected_events.size() != 0)
         report_mismatch("words never seen, count", 0, expected_events.size());
      $display("%0d bytes sent over six settings (equal syncs, zero and full limit, stalls);",
               bytes_sent);
      $display("%0d words checked: %0d payload, %0d good, %0d bad checksum, %0d too long",
               words_seen, kind_seen[slcd_pkg::EV_PAYLOAD], kind_seen[slcd_pkg::EV_GOOD],
               kind_seen[slcd_pkg::EV_BAD_SUM], kind_seen[slcd_pkg::EV_TOO_LONG]);
      if (errors == 0) begin
         $display("sync_length_checksum_deframer test passed");
      end else begin
         $display("sync_length_checksum_deframer test failed");
      end
      $finish;
   end

endmodule
